/* rtl/jdtm_pkg.sv */
// Shared types and constants for the joystick differential track mixer.
// No dependencies; used by the top level and the checker.
package jdtm_pkg;

  // Field widths of the stream payloads
  localparam int unsigned RawW   = 11;
  localparam int unsigned SpdW   = 8;
  localparam int unsigned BandW  = 8;
  localparam int unsigned InDW   = 24;
  localparam int unsigned OutDW  = 24;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CH_MIN = 2'd0,
    CFG_CH_MAX = 2'd1,
    CFG_DBAND  = 2'd2,
    CFG_SPARE  = 2'd3
  } jdtm_cfg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MAPX,
    S_MAPY,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_DIVX,
    S_DIVY,
    S_OUT
  } jdtm_state_e;

endpackage

/* rtl/joystick_differential_track_mixer_unit.sv */
// Top level of the joystick differential track mixer (arcade drive).
// Depends on jdtm_pkg, jdtm_div, jdtm_sqr and jdtm_sqrt.
//
//   channel   direction  payload
//   s_axis    in         tdata: steer_raw[10:0], throttle_raw[21:11]
//   m_axis    out        tdata: left/right speed, reverse and change flags
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One item at a time runs through a sequencer around a shared bit-serial
// divider, squarer and square root. The stick vector is scaled only when it
// lies outside the unit circle. The divider works on DW = max(2F+3, F+12)
// bits (F = 15: DW = 33).
// Reset clears the sequencer, direction bits and output valid; config takes its defaults.
// A stalled result sits in the output register; the next item is accepted
// meanwhile and waits at the end of its run for the register to free up.
module joystick_differential_track_mixer_unit
  import jdtm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDW-1:0]     s_axis_tdata,  // steer_raw, throttle_raw
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // left_speed, right_speed, left_reverse, right_reverse,
  // left_dir_changed, right_dir_changed
  output logic [OutDW-1:0]    m_axis_tdata,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [RawW-1:0]     cfg_data_i
);
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned AW  = F + 3;                     // axis width
  localparam int unsigned DW  = (2*F+3 > F+12) ? 2*F+3 : F+12;
  localparam int unsigned SW  = 2 * AW;                    // squared width
  localparam logic [DW-1:0] FourOne = DW'(1) << (F + 2);
  localparam logic [SW-1:0] OneSq   = SW'(1) << (2 * F);
  localparam logic signed [F+3:0] OneV = (F+4)'(1) << F;

  jdtm_state_e state_q, state_d;
  logic        launch_q;

  logic [RawW-1:0]  cmin_q, cmax_q;
  logic [BandW-1:0] dband_q;
  logic [RawW-1:0]  steer_q, throttle_q;
  logic signed [AW-1:0] x_q, y_q;
  logic [SW-1:0]    r2_q;
  logic [AW-1:0]    r_q;
  logic             ldir_q, rdir_q;
  logic             mvalid_q;
  logic [OutDW-1:0] mdata_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmin_q  <= RawW'(172);
      cmax_q  <= RawW'(1811);
      dband_q <= BandW'(10);
    end else if (cfg_we_i) begin
      unique case (jdtm_cfg_e'(cfg_idx_i))
        CFG_CH_MIN: cmin_q  <= cfg_data_i;
        CFG_CH_MAX: cmax_q  <= cfg_data_i;
        CFG_DBAND:  dband_q <= cfg_data_i[BandW-1:0];
        CFG_SPARE:  ;
      endcase
    end
  end

  // Linear map numerator and denominator of the current axis
  logic [RawW-1:0]      raw_sel;
  logic signed [12:0]   num;
  logic signed [11:0]   den;
  logic [11:0]          num_mag;
  logic [10:0]          den_mag;
  logic                 map_neg;
  logic                 map_st;

  assign map_st  = (state_q == S_MAPX) || (state_q == S_MAPY);
  assign raw_sel = (state_q == S_MAPX) ? steer_q : throttle_q;
  assign num = $signed({1'b0, raw_sel, 1'b0}) - $signed({2'b00, cmin_q})
             - $signed({2'b00, cmax_q});
  assign den = $signed({1'b0, cmax_q}) - $signed({1'b0, cmin_q});
  assign num_mag = num[12] ? 12'(-num) : num[11:0];
  assign den_mag = den[11] ? 11'(-den) : den[10:0];
  assign map_neg = num[12] ^ den[11];

  // Axis magnitudes
  logic [AW-1:0] xmag, ymag, amag;
  assign xmag = x_q[AW-1] ? AW'(-x_q) : x_q;
  assign ymag = y_q[AW-1] ? AW'(-y_q) : y_q;
  assign amag = (state_q == S_DIVX) ? xmag : ymag;

  // Shared serial units
  logic          div_start, div_done;
  logic [DW-1:0] div_dvd, div_quo;
  logic [AW-1:0] div_dvs;
  logic          sqr_start, sqr_done;
  logic [SW-1:0] sqr_prod;
  logic          rt_start, rt_done;
  logic [AW-1:0] rt_root;

  assign div_start = launch_q && (map_st || state_q == S_DIVX || state_q == S_DIVY);
  assign div_dvd   = map_st ? DW'({num_mag, {F{1'b0}}}) : DW'({amag, {F{1'b0}}});
  assign div_dvs   = map_st ? AW'(den_mag) : r_q;
  assign sqr_start = launch_q && (state_q == S_SQX || state_q == S_SQY);
  assign rt_start  = launch_q && (state_q == S_SQRT);

  jdtm_div #(.DW(DW), .DVW(AW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dvs), .done_o(div_done), .quo_o(div_quo)
  );

  jdtm_sqr #(.MW(AW)) u_sqr (
    .clk_i, .rst_ni, .start_i(sqr_start), .a_i(sqr_start && state_q == S_SQX ? xmag : ymag),
    .done_o(sqr_done), .prod_o(sqr_prod)
  );

  jdtm_sqrt #(.RW(AW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(rt_start), .rad_i(r2_q),
    .done_o(rt_done), .root_o(rt_root)
  );

  // Saturated map result and scaled component
  logic signed [AW-1:0] map_val, sc_val;
  logic [SW-1:0]        r2_sum;

  always_comb begin
    if (den == '0) begin
      map_val = '0;
    end else if (!map_neg) begin
      map_val = (div_quo >= FourOne) ? {1'b0, {(AW-1){1'b1}}} : div_quo[AW-1:0];
    end else begin
      map_val = (div_quo > FourOne) ? {1'b1, {(AW-1){1'b0}}} : AW'(-div_quo[AW-1:0]);
    end
  end

  assign sc_val = ((state_q == S_DIVX) ? x_q[AW-1] : y_q[AW-1])
                ? AW'(-div_quo[AW-1:0]) : div_quo[AW-1:0];
  assign r2_sum = r2_q + sqr_prod;

  // Track mixing, clipping, swap and speed scaling
  logic signed [F+3:0] lsum, rsum, lclip, rclip, lv, rv;
  logic [F:0]          lmag, rmag;
  logic [F+8:0]        lprod, rprod;
  logic [SpdW-1:0]     lspd, rspd, lout, rout;
  logic                lrev, rrev, lmove, rmove;

  assign lsum  = (F+4)'(y_q) + (F+4)'(x_q);
  assign rsum  = (F+4)'(y_q) - (F+4)'(x_q);
  assign lclip = (lsum > OneV) ? OneV : (lsum < -OneV) ? -OneV : lsum;
  assign rclip = (rsum > OneV) ? OneV : (rsum < -OneV) ? -OneV : rsum;

  always_comb begin
    if (lclip <= 0 && rclip <= 0) begin
      lv = rclip;
      rv = lclip;
    end else begin
      lv = lclip;
      rv = rclip;
    end
  end

  // Multiply by 255 as a shift and subtract, then drop the fraction.
  assign lmag  = lv[F+3] ? (F+1)'(-lv) : lv[F:0];
  assign rmag  = rv[F+3] ? (F+1)'(-rv) : rv[F:0];
  assign lprod = {lmag, 8'h00} - (F+9)'(lmag);
  assign rprod = {rmag, 8'h00} - (F+9)'(rmag);
  assign lspd  = lprod[F+7:F];
  assign rspd  = rprod[F+7:F];
  assign lmove = lspd > dband_q;
  assign rmove = rspd > dband_q;
  assign lout  = lmove ? lspd : '0;
  assign rout  = rmove ? rspd : '0;
  assign lrev  = lmove ? lv[F+3] : ldir_q;
  assign rrev  = rmove ? rv[F+3] : rdir_q;

  logic out_load;
  assign out_load = (state_q == S_OUT) && (!mvalid_q || m_axis_tready);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_MAPX;
      S_MAPX: if (div_done) state_d = S_MAPY;
      S_MAPY: if (div_done) state_d = S_SQX;
      S_SQX:  if (sqr_done) state_d = S_SQY;
      S_SQY:  if (sqr_done) state_d = (r2_sum > OneSq) ? S_SQRT : S_OUT;
      S_SQRT: if (rt_done) state_d = S_DIVX;
      S_DIVX: if (div_done) state_d = S_DIVY;
      S_DIVY: if (div_done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= state_d != state_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      steer_q    <= s_axis_tdata[RawW-1:0];
      throttle_q <= s_axis_tdata[2*RawW-1:RawW];
    end
    if ((state_q == S_MAPX && div_done) || (state_q == S_DIVX && div_done)) begin
      x_q <= map_st ? map_val : sc_val;
    end
    if ((state_q == S_MAPY && div_done) || (state_q == S_DIVY && div_done)) begin
      y_q <= map_st ? map_val : sc_val;
    end
    if (state_q == S_SQX && sqr_done) r2_q <= sqr_prod;
    if (state_q == S_SQY && sqr_done) r2_q <= r2_sum;
    if (rt_done) r_q <= rt_root;
    if (out_load) begin
      mdata_q <= OutDW'({rmove && (rv[F+3] != rdir_q), lmove && (lv[F+3] != ldir_q),
                         rrev, lrev, rout, lout});
    end
  end

  // Direction state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldir_q   <= 1'b0;
      rdir_q   <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      if (out_load) begin
        ldir_q   <= lrev;
        rdir_q   <= rrev;
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
endmodule

/* rtl/jdtm_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing but its parameters.
module jdtm_div #(
  parameter int unsigned DW  = 33,
  parameter int unsigned DVW = 18
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           done_o,
  output logic [DW-1:0]  quo_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DVW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [DVW:0]  trial;
  logic          fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DVW'(trial - {1'b0, divisor_i}) : trial[DVW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

/* rtl/jdtm_sqr.sv */
// Bit-serial squarer: one shift-add step per cycle over the operand bits.
// Depends on nothing but its parameters.
module jdtm_sqr #(
  parameter int unsigned MW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MW-1:0]   a_i,
  output logic            done_o,
  output logic [2*MW-1:0] prod_o
);
  localparam int unsigned CW = $clog2(MW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [MW-1:0]   mcand_q;
  logic [2*MW-1:0] prod_q;
  logic [MW:0]     psum;

  // Add the multiplicand into the upper half when the low bit is set.
  assign psum = {1'b0, prod_q[2*MW-1:MW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i;
      prod_q  <= {{MW{1'b0}}, a_i};
    end else if (busy_q) begin
      prod_q <= {psum, prod_q[MW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;
endmodule

/* rtl/jdtm_sqrt.sv */
// Digit-by-digit integer square root: one root bit per cycle.
// Depends on nothing but its parameters.
module jdtm_sqrt #(
  parameter int unsigned RW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] rad_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);
  localparam int unsigned CW = $clog2(RW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [2*RW-1:0] rad_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   tst;
  logic            fits;

  // Bring down two radicand bits and test against 4*root+1.
  assign rem_sh = {rem_q, rad_q[2*RW-1:2*RW-2]};
  assign tst    = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= tst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*RW-3:0], 2'b00};
      rem_q  <= fits ? (RW+1)'(rem_sh - tst) : rem_sh[RW:0];
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

/* rtl/jdtm_checker.sv */
// Port-level checks for the joystick differential track mixer.
// Depends on jdtm_pkg; bound to joystick_differential_track_mixer_unit.
module jdtm_checker
  import jdtm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OutDW-1:0] m_axis_tdata
);
  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // After a transfer in, the block is busy with that item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // A track inside the deadband never flips its direction.
  a_left_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:0] == '0 |-> !m_axis_tdata[18])
    else $error("left change flag with zero speed");

  a_right_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:8] == '0 |-> !m_axis_tdata[19])
    else $error("right change flag with zero speed");
endmodule

bind joystick_differential_track_mixer_unit jdtm_checker u_jdtm_checker (.*);
